[rtl/core/eatrm_pkg.sv]
// shared types, constants and the arctangent table for the euler angle matrix pipeline
`default_nettype none
package eatrm_pkg;

  localparam int ANGLE_W = 16;
  localparam int FLAGS_W = 32;
  localparam int SLOT_W  = 16;

  // default parameter values
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_TABLE_LEN  = 32;

  // angle reduction, units of 1/64 degree
  localparam int TURN_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;

  // radian scaling: pi*2^28 = 2880*K_DIV + R_DIV, then division by 2880 = 64*45
  localparam logic [18:0] K_DIV     = 19'd292817;
  localparam logic [10:0] R_DIV     = 11'd1897;
  localparam logic [10:0] HALF_DIV  = 11'd1440;
  localparam logic [18:0] RECIP_45  = 19'd372827;
  localparam int          RECIP_SH  = 24;
  localparam logic [5:0]  DIV_45    = 6'd45;

  // cordic datapath
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

  // flag update
  localparam logic [FLAGS_W-1:0] FLAGS_CLR_MASK = 32'hFFFF_FFFD;
  localparam logic [FLAGS_W-1:0] FLAGS_SET_MASK = 32'h0000_0001;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic [FLAGS_W-1:0]        flags_in;
  } in_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]       flags_out;
    logic signed [SLOT_W-1:0] slot1_value;
    logic signed [SLOT_W-1:0] slot2_value;
    logic signed [SLOT_W-1:0] slot3_value;
    logic signed [SLOT_W-1:0] slot5_value;
    logic signed [SLOT_W-1:0] slot6_value;
    logic signed [SLOT_W-1:0] slot7_value;
    logic signed [SLOT_W-1:0] slot9_value;
    logic signed [SLOT_W-1:0] slot10_value;
    logic signed [SLOT_W-1:0] slot11_value;
  } out_t;

  // arctangent of 2^-i in q30 radians
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:       v = 34'sh0_3243_F6A8;
      1:       v = 34'sh0_1DAC_6705;
      2:       v = 34'sh0_0FAD_BAFC;
      3:       v = 34'sh0_07F5_6EA6;
      4:       v = 34'sh0_03FE_AB76;
      5:       v = 34'sh0_01FF_D55B;
      6:       v = 34'sh0_00FF_FAAA;
      7:       v = 34'sh0_007F_FF55;
      8:       v = 34'sh0_003F_FFEA;
      9:       v = 34'sh0_001F_FFFD;
      10:      v = 34'sh0_000F_FFFF;
      11:      v = 34'sh0_0007_FFFF;
      12:      v = 34'sh0_0003_FFFF;
      13:      v = 34'sh0_0001_FFFF;
      14:      v = 34'sh0_0000_FFFF;
      15:      v = 34'sh0_0000_7FFF;
      16:      v = 34'sh0_0000_3FFF;
      17:      v = 34'sh0_0000_1FFF;
      18:      v = 34'sh0_0000_0FFF;
      19:      v = 34'sh0_0000_07FF;
      20:      v = 34'sh0_0000_03FF;
      21:      v = 34'sh0_0000_01FF;
      22:      v = 34'sh0_0000_00FF;
      23:      v = 34'sh0_0000_007F;
      24:      v = 34'sh0_0000_003F;
      25:      v = 34'sh0_0000_001F;
      26:      v = 34'sh0_0000_000F;
      27:      v = 34'sh0_0000_0008;
      28:      v = 34'sh0_0000_0004;
      29:      v = 34'sh0_0000_0002;
      30:      v = 34'sh0_0000_0001;
      default: v = 34'sh0_0000_0000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/euler_angles_to_rotation_matrix.sv]
// euler angles to rotation matrix words: angle reduction, three cordic lanes, product tree
// throughput: one beat per cycle; the whole pipeline holds when the output beat is not taken
// the per-stage cordic registers set the depth; each stage is one add, one multiply
// or the short quotient correction of the radian scaling
// reset clears the stage valid bits only; data registers are not reset
`default_nettype none
module euler_angles_to_rotation_matrix #(
  parameter int OUT_FRAC_BITS = eatrm_pkg::OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = eatrm_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire eatrm_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output eatrm_pkg::out_t      out_data
);

  localparam int CW = eatrm_pkg::CW;
  localparam int NS = (CORDIC_STAGES > eatrm_pkg::CORDIC_TABLE_LEN) ?
                      eatrm_pkg::CORDIC_TABLE_LEN : CORDIC_STAGES;
  localparam int SH = 60 - OUT_FRAC_BITS;
  localparam int T  = NS + 10;

  // pipeline advance and stage valid bits
  logic       adv;
  logic [T-1:0] vld_r;

  assign adv       = !vld_r[T-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[T-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[T-2:0], in_valid};
    end
  end

  // flag word, updated at entry and carried alongside
  logic [eatrm_pkg::FLAGS_W-1:0] fl_r [0:T-2];

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_r[0] <= (in_data.flags_in & eatrm_pkg::FLAGS_CLR_MASK) | eatrm_pkg::FLAGS_SET_MASK;
      for (int k = 1; k < T - 1; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // lane angles: pitch, yaw, roll
  logic signed [eatrm_pkg::ANGLE_W-1:0] ang [0:2];
  assign ang[0] = in_data.pitch_angle;
  assign ang[1] = in_data.yaw_angle;
  assign ang[2] = in_data.roll_angle;

  // cosine and sine of each lane after quadrant fixup
  logic signed [31:0] cos_r [0:2];
  logic signed [31:0] sin_r [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [16:0] a_ext;
    logic [14:0]        wrap;
    eatrm_pkg::quad_t   q_nxt;
    logic [12:0]        m_nxt;
    eatrm_pkg::quad_t   q1_r, q2_r, q3_r, q4_r;
    logic [12:0]        m1_r;
    logic [31:0]        mk2_r, mk3_r;
    logic [23:0]        nr2_r;
    logic [17:0]        n3_r;
    logic [36:0]        pr3_r;
    logic [11:0]        qe;
    logic [18:0]        rem;
    logic [11:0]        qd;
    logic signed [CW-1:0] z4_r;
    logic signed [CW-1:0] xin [0:NS-1];
    logic signed [CW-1:0] yin [0:NS-1];
    logic signed [CW-1:0] zin [0:NS-1];
    logic signed [CW-1:0] x_r [0:NS-1];
    logic signed [CW-1:0] y_r [0:NS-1];
    logic signed [CW-1:0] z_r [0:NS-1];
    eatrm_pkg::quad_t   qc_r [0:NS-1];
    logic signed [CW-1:0] neg_x, neg_y;
    logic signed [31:0] co_r, si_r;

    // wrap to one turn and split into quadrant and remainder
    always_comb begin
      a_ext = 17'(ang[g]);
      if (a_ext >= 17'sd23040) begin
        wrap = 15'(a_ext - 17'sd23040);
      end else if (a_ext >= 17'sd0) begin
        wrap = 15'(a_ext);
      end else if (a_ext >= -17'sd23040) begin
        wrap = 15'(a_ext + 17'sd23040);
      end else begin
        wrap = 15'(a_ext + 17'sd46080);
      end
      if (wrap >= 15'd17280) begin
        q_nxt = eatrm_pkg::QUAD_IV;
        m_nxt = 13'(wrap - 15'd17280);
      end else if (wrap >= 15'd11520) begin
        q_nxt = eatrm_pkg::QUAD_III;
        m_nxt = 13'(wrap - 15'd11520);
      end else if (wrap >= 15'd5760) begin
        q_nxt = eatrm_pkg::QUAD_II;
        m_nxt = 13'(wrap - 15'd5760);
      end else begin
        q_nxt = eatrm_pkg::QUAD_I;
        m_nxt = 13'(wrap);
      end
    end

    // radian scaling by pi/2880 with rounding, exact via reciprocal and correction
    always_comb begin
      qe  = pr3_r[eatrm_pkg::RECIP_SH+11:eatrm_pkg::RECIP_SH];
      rem = 19'(n3_r) - 19'(qe) * 19'(eatrm_pkg::DIV_45);
      qd  = (rem >= 19'(eatrm_pkg::DIV_45)) ? qe + 12'd1 : qe;
    end

    function automatic logic [36:0] n3_r_nxt_mul(input logic [17:0] n);
      return 37'(n) * 37'(eatrm_pkg::RECIP_45);
    endfunction

    always_ff @(posedge clk) begin
      if (adv) begin
        q1_r  <= q_nxt;
        m1_r  <= m_nxt;
        q2_r  <= q1_r;
        mk2_r <= 32'(m1_r) * 32'(eatrm_pkg::K_DIV);
        nr2_r <= 24'(m1_r) * 24'(eatrm_pkg::R_DIV) + 24'(eatrm_pkg::HALF_DIV);
        q3_r  <= q2_r;
        mk3_r <= mk2_r;
        n3_r  <= nr2_r[23:6];
        pr3_r <= n3_r_nxt_mul(nr2_r[23:6]);
        q4_r  <= q3_r;
        z4_r  <= CW'(mk3_r) + CW'(qd);
      end
    end

    // cordic stage inputs
    always_comb begin
      xin[0] = eatrm_pkg::CORDIC_GAIN;
      yin[0] = '0;
      zin[0] = z4_r;
      for (int i = 1; i < NS; i++) begin
        xin[i] = x_r[i-1];
        yin[i] = y_r[i-1];
        zin[i] = z_r[i-1];
      end
    end

    // cordic rotation stages, one register per iteration
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < NS; i++) begin
          if (!zin[i][CW-1]) begin
            x_r[i] <= xin[i] - (yin[i] >>> i);
            y_r[i] <= yin[i] + (xin[i] >>> i);
            z_r[i] <= zin[i] - eatrm_pkg::atan_q30(i);
          end else begin
            x_r[i] <= xin[i] + (yin[i] >>> i);
            y_r[i] <= yin[i] - (xin[i] >>> i);
            z_r[i] <= zin[i] + eatrm_pkg::atan_q30(i);
          end
        end
        qc_r[0] <= q4_r;
        for (int i = 1; i < NS; i++) begin
          qc_r[i] <= qc_r[i-1];
        end
      end
    end

    // quadrant fixup
    assign neg_x = -x_r[NS-1];
    assign neg_y = -y_r[NS-1];

    always_ff @(posedge clk) begin
      if (adv) begin
        case (qc_r[NS-1])
          eatrm_pkg::QUAD_I: begin
            co_r <= x_r[NS-1][31:0];
            si_r <= y_r[NS-1][31:0];
          end
          eatrm_pkg::QUAD_II: begin
            co_r <= neg_y[31:0];
            si_r <= x_r[NS-1][31:0];
          end
          eatrm_pkg::QUAD_III: begin
            co_r <= neg_x[31:0];
            si_r <= neg_y[31:0];
          end
          default: begin
            co_r <= y_r[NS-1][31:0];
            si_r <= neg_x[31:0];
          end
        endcase
      end
    end

    assign cos_r[g] = co_r;
    assign sin_r[g] = si_r;
  end

  // products, first level: exact q60 pairs
  logic signed [63:0] srsy_r, crsp_r, crcp_r, crsy_r, srsp_r, srcp_r, sycp_r, sysp_r;
  logic signed [63:0] cpcy_r, spcy_r;
  logic signed [31:0] cy1_r, sr1_r, cr1_r;
  // second level: rounded pair terms
  logic signed [31:0] cpcy_q_r, spcy_q_r;
  logic signed [63:0] srsy2_r, crsp2_r, crcp2_r, crsy2_r, srsp2_r, srcp2_r, sycp2_r, sysp2_r;
  logic signed [31:0] cy2_r, sr2_r, cr2_r;
  logic signed [63:0] cpcy_rnd, spcy_rnd;
  // third level: triple products
  logic signed [63:0] ta_r, tb_r, tc_r, td_r;
  logic signed [63:0] srsy3_r, crsp3_r, crcp3_r, crsy3_r, srsp3_r, srcp3_r, sycp3_r, sysp3_r;
  logic signed [31:0] cy3_r;
  // fourth level: slot sums
  logic signed [64:0] sum_r [0:8];
  eatrm_pkg::out_t    out_r;

  assign cpcy_rnd = (cpcy_r + 64'sd536870912) >>> 30;
  assign spcy_rnd = (spcy_r + 64'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      srsy_r <= sin_r[2] * sin_r[1];
      crsp_r <= cos_r[2] * sin_r[0];
      crcp_r <= cos_r[2] * cos_r[0];
      crsy_r <= cos_r[2] * sin_r[1];
      srsp_r <= sin_r[2] * sin_r[0];
      srcp_r <= sin_r[2] * cos_r[0];
      sycp_r <= sin_r[1] * cos_r[0];
      sysp_r <= sin_r[1] * sin_r[0];
      cpcy_r <= cos_r[0] * cos_r[1];
      spcy_r <= sin_r[0] * cos_r[1];
      cy1_r  <= cos_r[1];
      sr1_r  <= sin_r[2];
      cr1_r  <= cos_r[2];

      cpcy_q_r <= cpcy_rnd[31:0];
      spcy_q_r <= spcy_rnd[31:0];
      srsy2_r  <= srsy_r;
      crsp2_r  <= crsp_r;
      crcp2_r  <= crcp_r;
      crsy2_r  <= crsy_r;
      srsp2_r  <= srsp_r;
      srcp2_r  <= srcp_r;
      sycp2_r  <= sycp_r;
      sysp2_r  <= sysp_r;
      cy2_r    <= cy1_r;
      sr2_r    <= sr1_r;
      cr2_r    <= cr1_r;

      ta_r    <= cpcy_q_r * sr2_r;
      tb_r    <= spcy_q_r * sr2_r;
      tc_r    <= cpcy_q_r * cr2_r;
      td_r    <= spcy_q_r * cr2_r;
      srsy3_r <= srsy2_r;
      crsp3_r <= crsp2_r;
      crcp3_r <= crcp2_r;
      crsy3_r <= crsy2_r;
      srsp3_r <= srsp2_r;
      srcp3_r <= srcp2_r;
      sycp3_r <= sycp2_r;
      sysp3_r <= sysp2_r;
      cy3_r   <= cy2_r;

      sum_r[0] <= 65'(srsy3_r);
      sum_r[1] <= -65'(ta_r) - 65'(crsp3_r);
      sum_r[2] <= 65'(crcp3_r) - 65'(tb_r);
      sum_r[3] <= 65'(crsy3_r);
      sum_r[4] <= 65'(srsp3_r) - 65'(tc_r);
      sum_r[5] <= -65'(td_r) - 65'(srcp3_r);
      sum_r[6] <= 65'(cy3_r) <<< 30;
      sum_r[7] <= 65'(sycp3_r);
      sum_r[8] <= 65'(sysp3_r);
    end
  end

  // round to the output fraction and saturate
  function automatic logic signed [15:0] emit(input logic signed [64:0] v);
    logic signed [65:0] t;
    t = (66'(v) + (66'sd1 <<< (SH - 1))) >>> SH;
    if (t > 66'sd32767) begin
      return 16'sh7FFF;
    end else if (t < -66'sd32768) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.flags_out    <= fl_r[T-2];
      out_r.slot1_value  <= emit(sum_r[0]);
      out_r.slot2_value  <= emit(sum_r[1]);
      out_r.slot3_value  <= emit(sum_r[2]);
      out_r.slot5_value  <= emit(sum_r[3]);
      out_r.slot6_value  <= emit(sum_r[4]);
      out_r.slot7_value  <= emit(sum_r[5]);
      out_r.slot9_value  <= emit(sum_r[6]);
      out_r.slot10_value <= emit(sum_r[7]);
      out_r.slot11_value <= emit(sum_r[8]);
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the euler angle to rotation matrix pipeline
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LATENCY    = eatrm_pkg::CORDIC_STAGES_DEF + 10;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 500;
  localparam int N_LIMIT    = 32;
  localparam int SLOT_SH    = 60 - eatrm_pkg::OUT_FRAC_BITS_DEF;
  localparam longint PI_Q28_C = 64'sd843314857;
  localparam longint GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint ATAN_TBL [0:31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  eatrm_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  eatrm_pkg::out_t out_data;

  euler_angles_to_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // stimulus and expectations
  eatrm_pkg::in_t  angle_q[$];
  bit              drain_q[$];
  eatrm_pkg::out_t matrix_q[$];
  int   errors = 0;
  bit   in_beat, out_beat;
  bit   long_hold_done = 1'b0;

  // cosine and sine of one angle in q30
  function automatic void angle_sincos(input logic signed [15:0] ang,
                                       output longint co, output longint si);
    int a, q, m;
    longint x, y, z, dx, dy;
    a = int'(ang) % 23040;
    if (a < 0) a += 23040;
    q = a / 5760;
    m = a % 5760;
    z = (longint'(m) * PI_Q28_C + 1440) / 2880;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < eatrm_pkg::CORDIC_STAGES_DEF && i < N_LIMIT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    case (q)
      0: begin co = x; si = y; end
      1: begin co = -y; si = x; end
      2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic longint prod3(input longint a, input longint b, input longint c);
    return ((a * b + (64'sd1 <<< 29)) >>> 30) * c;
  endfunction

  // round q60 to the output fraction and saturate
  function automatic logic signed [15:0] to_slot(input longint q60);
    longint v;
    v = (q60 + (64'sd1 <<< (SLOT_SH - 1))) >>> SLOT_SH;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic eatrm_pkg::out_t rotation_words(input eatrm_pkg::in_t it);
    longint cp, sp, cy, sy, cr, sr;
    eatrm_pkg::out_t r;
    angle_sincos(it.pitch_angle, cp, sp);
    angle_sincos(it.yaw_angle, cy, sy);
    angle_sincos(it.roll_angle, cr, sr);
    r.flags_out    = (it.flags_in & 32'hFFFF_FFFD) | 32'h1;
    r.slot1_value  = to_slot(sr * sy);
    r.slot2_value  = to_slot(-prod3(cp, cy, sr) - cr * sp);
    r.slot3_value  = to_slot(cr * cp - prod3(cy, sp, sr));
    r.slot5_value  = to_slot(cr * sy);
    r.slot6_value  = to_slot(sr * sp - prod3(cy, cp, cr));
    r.slot7_value  = to_slot(-prod3(sp, cy, cr) - sr * cp);
    r.slot9_value  = to_slot(cy * (64'sd1 <<< 30));
    r.slot10_value = to_slot(sy * cp);
    r.slot11_value = to_slot(sy * sp);
    return r;
  endfunction

  task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
      errors++;
    end
  endtask

  // monitor: record accepted beats and check results
  always @(posedge clk) begin
    eatrm_pkg::out_t e;
    in_beat  = rst_n && in_valid && in_ready;
    out_beat = rst_n && out_valid && out_ready;
    if (in_beat) matrix_q.push_back(rotation_words(in_data));
    if (out_beat) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        errors++;
      end else begin
        e = matrix_q.pop_front();
        cmp_field("flags_out", e.flags_out, out_data.flags_out);
        cmp_field("slot1", 32'(e.slot1_value), 32'(out_data.slot1_value));
        cmp_field("slot2", 32'(e.slot2_value), 32'(out_data.slot2_value));
        cmp_field("slot3", 32'(e.slot3_value), 32'(out_data.slot3_value));
        cmp_field("slot5", 32'(e.slot5_value), 32'(out_data.slot5_value));
        cmp_field("slot6", 32'(e.slot6_value), 32'(out_data.slot6_value));
        cmp_field("slot7", 32'(e.slot7_value), 32'(out_data.slot7_value));
        cmp_field("slot9", 32'(e.slot9_value), 32'(out_data.slot9_value));
        cmp_field("slot10", 32'(e.slot10_value), 32'(out_data.slot10_value));
        cmp_field("slot11", 32'(e.slot11_value), 32'(out_data.slot11_value));
      end
    end
  end

  // driver: bursts and gaps, optional drain before an item
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_beat)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (angle_q.size() != 0 &&
                   !(drain_q[0] && (matrix_q.size() != 0 || in_valid))) begin
        burst_left--;
        drain_q[0] = 1'b0;
        void'(drain_q.pop_front());
        in_data  <= angle_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: randomly chosen stall patterns, one long hold-off
  int rx_cycle = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (rx_cycle >= 400 && rx_cycle < 600)
        out_ready <= 1'b0;
      else if (stall_mode == 0)
        out_ready <= 1'b1;
      else if (stall_mode == 1)
        out_ready <= ($urandom_range(0, 9) < 7);
      else
        out_ready <= ($urandom_range(0, 9) < 3);
    end else begin
      out_ready <= 1'b0;
    end
  end

  // watchdog on cycles without any beat
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(input logic [15:0] p, input logic [15:0] y, input logic [15:0] r,
                          input logic [31:0] f, input bit drain);
    eatrm_pkg::in_t it;
    it.pitch_angle = p;
    it.yaw_angle = y;
    it.roll_angle = r;
    it.flags_in = f;
    angle_q.push_back(it);
    drain_q.push_back(drain);
  endtask

  function automatic logic [15:0] rand_angle();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($signed($urandom_range(0, 46080)) - 23040);
    if (k < 8) return 16'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2) - 1);
    return 16'($urandom);
  endfunction

  initial begin
    // directed: quadrant edges, full turn, field extremes, flag patterns
    add_item(16'd0, 16'd0, 16'd0, 32'h0000_0000, 1'b0);
    add_item(16'd5760, 16'd5760, 16'd5760, 32'hFFFF_FFFF, 1'b0);
    add_item(16'd11520, 16'd11520, 16'd11520, 32'h0000_0002, 1'b0);
    add_item(16'd17280, 16'd17280, 16'd17280, 32'h0000_0001, 1'b0);
    add_item(16'd23040, -16'sd23040, 16'd23039, 32'h8000_0000, 1'b0);
    add_item(16'h7FFF, 16'h8000, 16'hFFFF, 32'h5555_5555, 1'b0);
    add_item(16'h8000, 16'h7FFF, 16'h0001, 32'hAAAA_AAAA, 1'b0);
    add_item(16'd5759, 16'd11519, 16'd17279, 32'hFFFF_FFFD, 1'b0);
    add_item(-16'sd5760, -16'sd11520, -16'sd17280, 32'h1234_5678, 1'b0);
    add_item(16'd2880, 16'd8640, 16'd14400, 32'h0000_0003, 1'b0);
    add_item(16'd20160, 16'd0, 16'd2880, 32'hDEAD_BEEF, 1'b0);
    add_item(16'd0, 16'd5760, 16'd0, 32'h7FFF_FFFF, 1'b0);
    for (int i = 0; i < RAND_ITEMS; i++)
      add_item(rand_angle(), rand_angle(), rand_angle(), $urandom, (i == 250));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // poll at the clock until every item is sent and every result checked
    do @(posedge clk);
    while (angle_q.size() != 0 || in_valid || matrix_q.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/eatrm_pkg.sv
rtl/core/euler_angles_to_rotation_matrix.sv
tb/tb.sv
